[design/dsf_pkg.sv]
`timescale 1ns / 1ps
package dsf_pkg;

    localparam int CHECKSUM_BYTES = 20;
    localparam logic [39:0] BYTES_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [39:0] LIMIT_RESET = 40'd16777216;
    localparam int IN_TDATA_W = 256;
    localparam int OUT_TDATA_W = 440;

    localparam logic OP_BLOCK = 1'b0;
    localparam logic OP_END = 1'b1;

    // initial hash values
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;      // latch input word
        logic stats;       // update counters and minimum
        logic put_byte;    // write one checksum byte into buffer
        logic pad_byte;    // write one padding byte at the current position
        logic put_len;     // write length into words 14 and 15
        logic comp_start;  // load working vars from chain
        logic round;       // one compression round
        logic comp_end;    // add working vars into chain
        logic fin_load;    // load working vars from final hash, schedule from buffer
        logic fin_round;   // round on final copy
        logic fin_end;     // add into final copy
        logic emit;        // load output register and restart segment
    } dsf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_end;
        logic size_zero;
        logic limit_hit;
        logic [5:0] pos;   // buffer write position, message length mod 64 until padding
    } dsf_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

[design/dsf_datapath.sv]
`timescale 1ns / 1ps
module dsf_datapath
(
    input  logic clk,
    input  logic rst_n,
    input  dsf_pkg::dsf_cmd_t cmd,
    output dsf_pkg::dsf_stat_t stat,
    input  logic [6:0] round_idx,
    input  logic [4:0] byte_idx,
    input  logic [dsf_pkg::IN_TDATA_W-1:0] in_word,
    input  logic in_op,
    input  logic [39:0] limit,
    output logic [dsf_pkg::OUT_TDATA_W-1:0] result
);

    logic        op_reg;
    logic [63:0] ck_hi_reg, ck_mid_reg, off_reg;
    logic [31:0] ck_lo_reg;
    logic [30:0] bsize_reg;

    logic [31:0] chain_reg [5];
    logic [31:0] fin_reg [5];
    logic [31:0] buf_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] len_reg;
    logic [63:0] min_hi_reg, min_mid_reg;
    logic [31:0] min_lo_reg;
    logic [39:0] bytes_reg;
    logic [63:0] first_reg;
    logic [15:0] count_reg;
    logic        pad_first_reg;
    logic [5:0]  pad_pos_reg;
    logic [dsf_pkg::OUT_TDATA_W-1:0] result_reg;

    // current checksum byte, big-endian
    logic [159:0] ck_all;
    logic [7:0]   ck_byte;
    logic [7:0]   wr_byte;
    logic [5:0]   pos;
    logic [31:0]  f, k, tmp, wt, wnew;
    logic [40:0]  bytes_sum;
    logic         less;

    assign ck_all = {ck_hi_reg, ck_mid_reg, ck_lo_reg};
    assign ck_byte = ck_all[159 - 8*byte_idx -: 8];
    // padding walks its own position, starting where the message ends
    assign pos = pad_first_reg ? len_reg[5:0] : pad_pos_reg;
    assign wr_byte = cmd.put_byte ? ck_byte : (pad_first_reg ? 8'h80 : 8'h00);

    assign stat.is_end = op_reg;
    assign stat.size_zero = (bsize_reg == 31'd0);
    assign stat.limit_hit = (bytes_reg >= limit);
    assign stat.pos = pos;

    assign less = (ck_hi_reg < min_hi_reg) ||
                  (ck_hi_reg == min_hi_reg && (ck_mid_reg < min_mid_reg ||
                  (ck_mid_reg == min_mid_reg && ck_lo_reg < min_lo_reg)));
    assign bytes_sum = {1'b0, bytes_reg} + {10'd0, bsize_reg};

    // round function
    assign wt = w_reg[0];
    assign wnew = dsf_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    always_comb
    begin
        if (round_idx < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (round_idx < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (round_idx < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        tmp = dsf_pkg::rotl(a_reg, 5) + f + e_reg + k + wt;
    end

    // control-like registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= dsf_pkg::H0;
            chain_reg[1] <= dsf_pkg::H1;
            chain_reg[2] <= dsf_pkg::H2;
            chain_reg[3] <= dsf_pkg::H3;
            chain_reg[4] <= dsf_pkg::H4;
            len_reg <= '0;
            bytes_reg <= '0;
            first_reg <= '0;
            count_reg <= '0;
            pad_first_reg <= 1'b1;
        end
        else
        begin
            if (cmd.stats)
            begin
                if (count_reg == 16'd0)
                    first_reg <= off_reg;
                if (count_reg != dsf_pkg::COUNT_MAX)
                    count_reg <= count_reg + 16'd1;
                bytes_reg <= bytes_sum[40] ? dsf_pkg::BYTES_MAX : bytes_sum[39:0];
            end
            if (cmd.put_byte)
                len_reg <= len_reg + 64'd1;
            if (cmd.pad_byte)
                pad_first_reg <= 1'b0;
            if (cmd.comp_end)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (cmd.emit)
            begin
                chain_reg[0] <= dsf_pkg::H0;
                chain_reg[1] <= dsf_pkg::H1;
                chain_reg[2] <= dsf_pkg::H2;
                chain_reg[3] <= dsf_pkg::H3;
                chain_reg[4] <= dsf_pkg::H4;
                len_reg <= '0;
                bytes_reg <= '0;
                first_reg <= '0;
                count_reg <= '0;
                pad_first_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= in_op;
            ck_hi_reg <= in_word[63:0];
            ck_mid_reg <= in_word[127:64];
            ck_lo_reg <= in_word[159:128];
            bsize_reg <= in_word[190:160];
            off_reg <= in_word[254:191];
        end
        if (cmd.stats && (count_reg == 16'd0 || less))
        begin
            min_hi_reg <= ck_hi_reg;
            min_mid_reg <= ck_mid_reg;
            min_lo_reg <= ck_lo_reg;
        end
        if (cmd.put_byte || cmd.pad_byte)
            buf_reg[pos[5:2]][31 - 8*pos[1:0] -: 8] <= wr_byte;
        if (cmd.pad_byte)
            pad_pos_reg <= pos + 6'd1;
        if (cmd.put_len)
        begin
            buf_reg[14] <= len_reg[60:29];
            buf_reg[15] <= {len_reg[28:0], 3'b000};
        end
        if (cmd.comp_start || cmd.fin_load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= buf_reg[i];
        end
        else if (cmd.round || cmd.fin_round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
        end
        if (cmd.comp_start)
        begin
            a_reg <= chain_reg[0]; b_reg <= chain_reg[1]; c_reg <= chain_reg[2];
            d_reg <= chain_reg[3]; e_reg <= chain_reg[4];
        end
        else if (cmd.fin_load)
        begin
            a_reg <= fin_reg[0]; b_reg <= fin_reg[1]; c_reg <= fin_reg[2];
            d_reg <= fin_reg[3]; e_reg <= fin_reg[4];
        end
        else if (cmd.round || cmd.fin_round)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= dsf_pkg::rotl(b_reg, 30);
            b_reg <= a_reg;
            a_reg <= tmp;
        end
        if (cmd.comp_end)
        begin
            fin_reg[0] <= chain_reg[0] + a_reg;
            fin_reg[1] <= chain_reg[1] + b_reg;
            fin_reg[2] <= chain_reg[2] + c_reg;
            fin_reg[3] <= chain_reg[3] + d_reg;
            fin_reg[4] <= chain_reg[4] + e_reg;
        end
        else if (cmd.fin_end)
        begin
            fin_reg[0] <= fin_reg[0] + a_reg;
            fin_reg[1] <= fin_reg[1] + b_reg;
            fin_reg[2] <= fin_reg[2] + c_reg;
            fin_reg[3] <= fin_reg[3] + d_reg;
            fin_reg[4] <= fin_reg[4] + e_reg;
        end
        else if (cmd.pad_byte && pad_first_reg)
        begin
            for (int i = 0; i < 5; i++)
                fin_reg[i] <= chain_reg[i];
        end
        if (cmd.emit)
        begin
            result_reg <= {count_reg,
                           (count_reg != 16'd0) ? first_reg : 64'd0,
                           bytes_reg,
                           (count_reg != 16'd0) ? min_lo_reg : 32'd0,
                           (count_reg != 16'd0) ? min_mid_reg : 64'd0,
                           (count_reg != 16'd0) ? min_hi_reg : 64'd0,
                           fin_reg[4],
                           fin_reg[2], fin_reg[3],
                           fin_reg[0], fin_reg[1]};
        end
    end

    assign result = result_reg;

endmodule

[design/dsf_ctrl.sv]
`timescale 1ns / 1ps
module dsf_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  dsf_pkg::dsf_stat_t stat,
    output dsf_pkg::dsf_cmd_t cmd,
    output logic [6:0] round_idx,
    output logic [4:0] byte_idx
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_BYTE   = 4'd2;
    localparam logic [3:0] S_CSTART = 4'd3;
    localparam logic [3:0] S_CROUND = 4'd4;
    localparam logic [3:0] S_CEND   = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_PAD    = 4'd7;
    localparam logic [3:0] S_LEN    = 4'd8;
    localparam logic [3:0] S_FLOAD  = 4'd9;
    localparam logic [3:0] S_FROUND = 4'd10;
    localparam logic [3:0] S_FEND   = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_FNEXT  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [4:0] byte_reg, byte_next;
    logic       out_valid_reg, out_valid_next;
    logic       second_reg, second_next;   // padding needs a second block

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign round_idx = round_reg;
    assign byte_idx = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            byte_reg <= '0;
            out_valid_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            byte_reg <= byte_next;
            out_valid_reg <= out_valid_next;
            second_reg <= second_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        byte_next = byte_reg;
        second_next = second_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_fire;
                if (in_fire)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.is_end)
                    state_next = S_CHECK;
                else if (stat.size_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.stats = 1'b1;
                    byte_next = '0;
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                cmd.put_byte = 1'b1;
                byte_next = byte_reg + 5'd1;
                if (stat.pos == 6'd63)
                    state_next = S_CSTART;
                else if (byte_reg == 5'(dsf_pkg::CHECKSUM_BYTES - 1))
                    state_next = S_CHECK;
            end
            S_CSTART:
            begin
                cmd.comp_start = 1'b1;
                round_next = '0;
                state_next = S_CROUND;
            end
            S_CROUND:
            begin
                cmd.round = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79)
                    state_next = S_CEND;
            end
            S_CEND:
            begin
                cmd.comp_end = 1'b1;
                if (byte_reg == 5'(dsf_pkg::CHECKSUM_BYTES))
                    state_next = S_CHECK;
                else
                    state_next = S_BYTE;
            end
            S_CHECK:
            begin
                // close on end of input or limit reached
                if (stat.is_end || stat.limit_hit)
                begin
                    second_next = (stat.pos > 6'd55);
                    state_next = S_PAD;
                end
                else
                    state_next = S_IDLE;
            end
            S_PAD:
            begin
                cmd.pad_byte = 1'b1;
                cmd.put_byte = 1'b0;
                if (second_reg && stat.pos == 6'd63)
                    state_next = S_FLOAD;
                else if (!second_reg && stat.pos == 6'd55)
                    state_next = S_LEN;
                round_next = '0;
            end
            S_LEN:
            begin
                cmd.put_len = 1'b1;
                state_next = S_FLOAD;
            end
            S_FLOAD:
            begin
                cmd.fin_load = 1'b1;
                round_next = '0;
                state_next = S_FROUND;
            end
            S_FROUND:
            begin
                cmd.fin_round = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79)
                    state_next = S_FEND;
            end
            S_FEND:
            begin
                cmd.fin_end = 1'b1;
                if (second_reg)
                begin
                    second_next = 1'b0;
                    state_next = S_FNEXT;
                end
                else
                    state_next = S_EMIT;
            end
            S_FNEXT:
            begin
                // second padding block: zeros up to byte 55
                cmd.pad_byte = 1'b1;
                if (stat.pos == 6'd55)
                    state_next = S_LEN;
            end
            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.emit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    property p_emit_only_when_free;
        @(posedge clk) disable iff (!rst_n) cmd.emit |-> !out_valid_reg;
    endproperty
    a_emit_free: assert property (p_emit_only_when_free)
        else $error("result overwritten");

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_fire |=> (state_reg == S_DEC);
    endproperty
    a_ready_idle: assert property (p_ready_idle)
        else $error("accept outside idle");

    property p_round_bound;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_CROUND || state_reg == S_FROUND) |-> round_reg < 7'd80;
    endproperty
    a_round_bound: assert property (p_round_bound)
        else $error("round index out of range");

endmodule

[design/dedup_segment_fingerprinter.sv]
`timescale 1ns / 1ps
// channel   | dir | fields
// s_axis    | in  | tdata: cksum_high, cksum_middle, cksum_low, block_size, block_offset
//           |     | tuser: opcode
// m_axis    | out | tdata: digest_high, digest_middle, digest_low, minhash_high,
//           |     |        minhash_middle, minhash_low, segment_bytes, first_offset,
//           |     |        block_count; tuser: segment_nonempty
// cfg       | in  | segment_size_limit
// a block record writes its checksum bytes into the message buffer and runs a
// compression each time the buffer fills; a zero-size block record is skipped
// a close adds padding and one or two final compressions;
// one shared 80-round unit runs every compression
// reset loads the initial hash chain and clears all counters at once
// one result register: the next item is taken while a result waits, but a
// further close stalls until that result leaves
module dedup_segment_fingerprinter
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // cksum_high, cksum_middle, cksum_low, block_size, block_offset
    input  logic s_axis_tuser,          // opcode
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [439:0] m_axis_tdata,  // digest h/m/l, minhash h/m/l, bytes, first_offset, count
    output logic m_axis_tuser,          // segment_nonempty
    input  logic cfg_wr_en,
    input  logic [39:0] cfg_wr_data
);

    logic [39:0] limit_reg;
    dsf_pkg::dsf_cmd_t cmd;
    dsf_pkg::dsf_stat_t stat;
    logic [6:0] round_idx;
    logic [4:0] byte_idx;
    logic [439:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= dsf_pkg::LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    dsf_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd), .round_idx(round_idx), .byte_idx(byte_idx)
    );

    dsf_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .round_idx(round_idx), .byte_idx(byte_idx),
        .in_word(s_axis_tdata), .in_op(s_axis_tuser),
        .limit(limit_reg), .result(result)
    );

    assign m_axis_tdata = result;
    assign m_axis_tuser = (result[439:424] != 16'd0);

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT = 300;

    typedef struct packed {
        logic nonempty;
        logic [439:0] fields;
    } segment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [255:0] s_axis_tdata = '0;  // cksum_high, cksum_middle, cksum_low, block_size, block_offset
    logic s_axis_tuser = dsf_pkg::OP_BLOCK;    // opcode
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [439:0] m_axis_tdata;       // digest h/m/l, minhash h/m/l, bytes, first_offset, count
    logic m_axis_tuser;               // segment_nonempty
    logic cfg_wr_en = 1'b0;
    logic [39:0] cfg_wr_data = '0;

    // predictor state
    logic [39:0] size_limit;
    logic [159:0] chain;
    logic [511:0] msg_buf;
    logic [63:0] msg_len;
    logic [159:0] min_cksum;
    logic [39:0] total_bytes;
    logic [63:0] first_off;
    logic [15:0] n_blocks;

    segment_t pending_segments[$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    logic [159:0] last_cksum = '0;

    dedup_segment_fingerprinter dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // one 80-round sha-1 compression
    function automatic logic [159:0] sha_block(input logic [159:0] h, input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, tmp, x;
        a = h[159:128];
        b = h[127:96];
        c = h[95:64];
        d = h[63:32];
        e = h[31:0];
        for (int t = 0; t < 16; t++)
            w[t] = blk[511 - 32 * t -: 32];
        for (int t = 16; t < 80; t++)
        begin
            x = w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16];
            w[t] = {x[30:0], x[31]};
        end
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function automatic void restart_segment();
        chain = {dsf_pkg::H0, dsf_pkg::H1, dsf_pkg::H2, dsf_pkg::H3, dsf_pkg::H4};
        msg_buf = '0;
        msg_len = '0;
        min_cksum = '0;
        total_bytes = '0;
        first_off = '0;
        n_blocks = '0;
    endfunction

    // pad, append bit length, and queue the closing segment
    function automatic void close_segment();
        logic [159:0] h;
        logic [511:0] blk;
        logic [63:0] bits;
        int pos;
        logic ne;
        segment_t s;
        h = chain;
        blk = msg_buf;
        pos = int'(msg_len[5:0]);
        bits = msg_len << 3;
        ne = (n_blocks != 0);
        blk[511 - 8 * pos -: 8] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                blk[511 - 8 * pos -: 8] = 8'h00;
                pos++;
            end
            h = sha_block(h, blk);
            pos = 0;
        end
        while (pos < 56)
        begin
            blk[511 - 8 * pos -: 8] = 8'h00;
            pos++;
        end
        blk[63:0] = bits;
        h = sha_block(h, blk);
        s.nonempty = ne;
        s.fields = {n_blocks, ne ? first_off : 64'd0, total_bytes,
                    ne ? min_cksum[31:0] : 32'd0, ne ? min_cksum[95:32] : 64'd0,
                    ne ? min_cksum[159:96] : 64'd0,
                    h[31:0], h[95:32], h[159:96]};
        pending_segments.insert(pending_segments.size(), s);
        restart_segment();
    endfunction

    function automatic void predict_segment(input logic op, input logic [159:0] ck,
                                            input logic [30:0] size, input logic [63:0] off);
        logic [40:0] sum;
        if (op == dsf_pkg::OP_END)
        begin
            close_segment();
            return;
        end
        if (size == 0)
            return;
        if (n_blocks == 0)
        begin
            first_off = off;
            min_cksum = ck;
        end
        else if (ck < min_cksum)
            min_cksum = ck;
        if (n_blocks != dsf_pkg::COUNT_MAX)
            n_blocks++;
        sum = {1'b0, total_bytes} + 41'(size);
        total_bytes = sum[40] ? dsf_pkg::BYTES_MAX : sum[39:0];
        for (int i = 0; i < dsf_pkg::CHECKSUM_BYTES; i++)
        begin
            msg_buf[511 - 8 * int'(msg_len[5:0]) -: 8] = ck[159 - 8 * i -: 8];
            msg_len++;
            if (msg_len[5:0] == 0)
                chain = sha_block(chain, msg_buf);
        end
        if (total_bytes >= size_limit)
            close_segment();
    endfunction

    task automatic send_word(input logic op, input logic [159:0] ck,
                             input logic [30:0] size, input logic [63:0] off);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, off, size, ck[31:0], ck[95:32], ck[159:96]};
        do @(posedge clk); while (!s_axis_tready);
        predict_segment(op, ck, size, off);
    endtask

    // hold off until every segment is out, then write the limit
    task automatic set_limit(input logic [39:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_limit = v;
    endtask

    function automatic logic [159:0] rand_cksum();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_offset();
        return {$urandom, $urandom};
    endfunction

    // result checker
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        segment_t want;
        logic [439:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_segments.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_segments.pop_front();
                got = m_axis_tdata;
                compare_field("segment_nonempty", 64'(want.nonempty), 64'(m_axis_tuser));
                compare_field("digest_high", want.fields[63:0], got[63:0]);
                compare_field("digest_middle", want.fields[127:64], got[127:64]);
                compare_field("digest_low", 64'(want.fields[159:128]), 64'(got[159:128]));
                compare_field("minhash_high", want.fields[223:160], got[223:160]);
                compare_field("minhash_middle", want.fields[287:224], got[287:224]);
                compare_field("minhash_low", 64'(want.fields[319:288]), 64'(got[319:288]));
                compare_field("segment_bytes", 64'(want.fields[359:320]),
                              64'(got[359:320]));
                compare_field("first_offset", want.fields[423:360], got[423:360]);
                compare_field("block_count", 64'(want.fields[439:424]), 64'(got[439:424]));
            end
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 15);
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // empty segment, extremes, skip, tie, limit of one and zero, padding spill
    task automatic test_directed();
        send_word(dsf_pkg::OP_END, '0, '0, '0);
        send_word(dsf_pkg::OP_BLOCK, {160{1'b1}}, 31'h7FFF_FFFF, {64{1'b1}});
        send_word(dsf_pkg::OP_BLOCK, '0, 31'd1, '0);
        send_word(dsf_pkg::OP_BLOCK, '0, 31'd0, 64'h1234);
        send_word(dsf_pkg::OP_BLOCK, '0, 31'd5, 64'h55);
        send_word(dsf_pkg::OP_END, {160{1'b1}}, 31'h7FFF_FFFF, {64{1'b1}});
        // three blocks leave 60 bytes so padding spills into a second block
        for (int i = 0; i < 3; i++)
            send_word(dsf_pkg::OP_BLOCK, rand_cksum(), 31'd100, rand_offset());
        send_word(dsf_pkg::OP_END, '0, '0, '0);
        set_limit(40'd1);
        for (int i = 0; i < 4; i++)
            send_word(dsf_pkg::OP_BLOCK, rand_cksum(), 31'd1, rand_offset());
        send_word(dsf_pkg::OP_END, '0, '0, '0);
        set_limit(40'd0);
        for (int i = 0; i < 3; i++)
            send_word(dsf_pkg::OP_BLOCK, rand_cksum(), 31'($urandom_range(1, 9)),
                      rand_offset());
        send_word(dsf_pkg::OP_BLOCK, '0, 31'd0, '0);
    endtask

    // byte total saturates at the top of its range
    task automatic test_saturate_bytes();
        set_limit(dsf_pkg::BYTES_MAX);
        quiet = 1'b1;
        for (int i = 0; i < 515; i++)
            send_word(dsf_pkg::OP_BLOCK, rand_cksum(), 31'h7FFF_FFFF, rand_offset());
        quiet = 1'b0;
        send_word(dsf_pkg::OP_END, '0, '0, '0);
    endtask

    task automatic random_phase(input logic [39:0] lim, input int count, input int max_size);
        logic [159:0] ck;
        logic [30:0] size;
        int r;
        set_limit(lim);
        for (int i = 0; i < count; i++)
        begin
            quiet = ((i / 4) % 4 == 3);
            r = $urandom_range(0, 99);
            if (r < 20)
                ck = last_cksum ^ (160'(1) << $urandom_range(0, 40));
            else if (r < 27)
                ck = last_cksum;
            else
                ck = rand_cksum();
            last_cksum = ck;
            r = $urandom_range(0, 99);
            if (r < 8)
                size = '0;
            else if (r < 12)
                size = 31'($urandom);
            else
                size = 31'($urandom_range(1, max_size));
            send_word(($urandom_range(0, 99) < 6) ? dsf_pkg::OP_END : dsf_pkg::OP_BLOCK,
                      ck, size, rand_offset());
        end
        quiet = 1'b0;
        send_word(dsf_pkg::OP_END, '0, '0, '0);
    endtask

    task automatic test_random();
        random_phase(40'($urandom_range(1, 4000)), 24, 600);
        random_phase(40'({$urandom, $urandom}), 16, 2000);
        random_phase(40'd1, 10, 50);
        random_phase(dsf_pkg::BYTES_MAX, 12, 1000);
        random_phase(dsf_pkg::LIMIT_RESET, 14, 2000);
    endtask

    initial
    begin
        size_limit = dsf_pkg::LIMIT_RESET;
        restart_segment();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturate_bytes();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
